>>> sv/fle_pkg.sv
package fle_pkg;

	// Field and register widths.
	localparam int CHAR_W  = 8;
	localparam int SLEN_W  = 16;
	localparam int WIDTH_W = 16;
	localparam int OUT_W   = 32;
	localparam int CFG_W   = 8;
	localparam int CFG_IDX_W = 2;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_INT_DEFAULT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FLOAT_DEFAULT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POINTER       = 2'd2;

	// Register reset values.
	localparam logic [CFG_W-1:0] INT_DEFAULT_RST   = 8'd10;
	localparam logic [CFG_W-1:0] FLOAT_DEFAULT_RST = 8'd15;
	localparam logic [CFG_W-1:0] POINTER_RST       = 8'd10;

	localparam logic [WIDTH_W-1:0] WIDTH_MAX = 16'hFFFF;

	// Character codes.
	localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
	localparam logic [CHAR_W-1:0] CH_PERCENT = "%";
	localparam logic [CHAR_W-1:0] CH_DOT     = ".";
	localparam logic [CHAR_W-1:0] CH_0       = "0";
	localparam logic [CHAR_W-1:0] CH_9       = "9";
	localparam logic [CHAR_W-1:0] CH_UC_A    = "A";
	localparam logic [CHAR_W-1:0] CH_UC_Z    = "Z";
	localparam logic [CHAR_W-1:0] CH_LC_A    = "a";
	localparam logic [CHAR_W-1:0] CH_LC_Z    = "z";

	// Conversion letters.
	localparam logic [CHAR_W-1:0] CH_D    = "d";
	localparam logic [CHAR_W-1:0] CH_I    = "i";
	localparam logic [CHAR_W-1:0] CH_O    = "o";
	localparam logic [CHAR_W-1:0] CH_X_LC = "x";
	localparam logic [CHAR_W-1:0] CH_X_UC = "X";
	localparam logic [CHAR_W-1:0] CH_U    = "u";
	localparam logic [CHAR_W-1:0] CH_F    = "f";
	localparam logic [CHAR_W-1:0] CH_G_LC = "g";
	localparam logic [CHAR_W-1:0] CH_E_LC = "e";
	localparam logic [CHAR_W-1:0] CH_G_UC = "G";
	localparam logic [CHAR_W-1:0] CH_E_UC = "E";
	localparam logic [CHAR_W-1:0] CH_S    = "s";
	localparam logic [CHAR_W-1:0] CH_C    = "c";
	localparam logic [CHAR_W-1:0] CH_P    = "p";
	localparam logic [CHAR_W-1:0] CH_N    = "n";
	localparam logic [CHAR_W-1:0] CH_L_LC = "l";
	localparam logic [CHAR_W-1:0] CH_H    = "h";
	localparam logic [CHAR_W-1:0] CH_L_UC = "L";
	localparam logic [CHAR_W-1:0] CH_W    = "w";

endpackage

>>> sv/format_length_estimator.sv
// Format length estimator.
//
// The block reads a printf-style format string one byte per transfer on the
// input channel (in_valid/in_ready with format_char and string_arg_length)
// and keeps a running upper bound on the length of the formatted output.
// A NUL byte closes the string: its transfer produces exactly one transfer
// on the output channel (out_valid/out_ready with estimated_length), and the
// scanner clears itself for the next string. No other byte produces output.
//
// A byte is captured in an input register and processed from there, which
// updates the scan state (mode, width, running total); the total for a NUL
// byte goes from there into the output register, so it reaches the output
// channel through both registers. Throughput is one byte per cycle as long
// as no NUL byte is held back by a stalled receiver.
// While a total waits on a stalled receiver, ordinary bytes keep flowing;
// only a second NUL byte waits in the input register until the output
// register frees up, and in_ready then drops.
// Reset clears the scan state, both channel registers and restores the
// default widths of the three configuration registers; the user must write them
// through the cfg_wr_en/cfg_addr/cfg_wdata port while the block is idle (not enforced).
module format_length_estimator #(
	parameter int LENGTH_BITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write port.
	input  logic                               cfg_wr_en,
	input  logic [fle_pkg::CFG_IDX_W-1:0]      cfg_addr,
	input  logic [fle_pkg::CFG_W-1:0]          cfg_wdata,
	// Input channel.
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [fle_pkg::CHAR_W-1:0]         format_char,
	input  logic [fle_pkg::SLEN_W-1:0]         string_arg_length,
	// Output channel.
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [fle_pkg::OUT_W-1:0]          estimated_length
);

	typedef enum logic [1:0] {
		MODE_TEXT,
		MODE_SPEC,
		MODE_DOT
	} mode_t;

	// Configuration registers.
	logic [fle_pkg::CFG_W-1:0] int_default_q;
	logic [fle_pkg::CFG_W-1:0] float_default_q;
	logic [fle_pkg::CFG_W-1:0] pointer_q;

	// Input register stage.
	logic                        valid_s1;
	logic [fle_pkg::CHAR_W-1:0]  char_s1;
	logic [fle_pkg::SLEN_W-1:0]  slen_s1;

	// Scan state.
	mode_t                        mode_q;
	logic [fle_pkg::WIDTH_W-1:0]  width_q;
	logic [LENGTH_BITS-1:0]       total_q;

	// Output register.
	logic                         out_valid_q;
	logic [fle_pkg::OUT_W-1:0]    out_len_q;

	// Next-state logic.
	logic                         is_nul;
	logic                         is_letter;
	logic                         is_numeral;
	logic                         s1_fire;
	logic                         do_add;
	logic [fle_pkg::WIDTH_W-1:0]  add_len;
	mode_t                        mode_d;
	logic [fle_pkg::WIDTH_W-1:0]  width_d;
	logic [fle_pkg::WIDTH_W+3:0]  width_mul;
	logic [LENGTH_BITS:0]         total_sum;
	logic [LENGTH_BITS-1:0]       total_add;
	logic [LENGTH_BITS+fle_pkg::OUT_W-1:0] total_ext;
	logic [fle_pkg::OUT_W-1:0]    total_out;

	assign is_nul    = (char_s1 == fle_pkg::CH_NUL);
	assign is_letter = ((char_s1 >= fle_pkg::CH_UC_A) && (char_s1 <= fle_pkg::CH_UC_Z)) ||
		((char_s1 >= fle_pkg::CH_LC_A) && (char_s1 <= fle_pkg::CH_LC_Z));
	assign is_numeral = (char_s1 >= fle_pkg::CH_0) && (char_s1 <= fle_pkg::CH_9);

	// The byte in the input register is processed this cycle unless it is a
	// NUL whose total has nowhere to go yet.
	assign s1_fire  = valid_s1 && (!is_nul || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_fire;

	// Width times ten plus the digit, worked as two shifts and an add.
	assign width_mul = {1'b0, width_q, 3'b000} + {3'b000, width_q, 1'b0} +
		{16'd0, char_s1[3:0]};

	// Conversion letters and all other bytes, by mode.
	always_comb begin
		mode_d  = mode_q;
		width_d = width_q;
		do_add  = 1'b0;
		add_len = fle_pkg::WIDTH_W'(1);
		if ((mode_q == MODE_SPEC || mode_q == MODE_DOT) && is_letter) begin
			mode_d = MODE_TEXT;
			unique case (char_s1)
				fle_pkg::CH_L_LC, fle_pkg::CH_H, fle_pkg::CH_L_UC, fle_pkg::CH_W: begin
					mode_d = MODE_SPEC;
				end
				fle_pkg::CH_D, fle_pkg::CH_I, fle_pkg::CH_O, fle_pkg::CH_X_LC,
				fle_pkg::CH_X_UC, fle_pkg::CH_U: begin
					do_add  = 1'b1;
					add_len = (width_q != '0) ? width_q :
						fle_pkg::WIDTH_W'(int_default_q);
				end
				fle_pkg::CH_F, fle_pkg::CH_G_LC, fle_pkg::CH_E_LC,
				fle_pkg::CH_G_UC, fle_pkg::CH_E_UC: begin
					do_add  = 1'b1;
					add_len = (width_q != '0) ? width_q :
						fle_pkg::WIDTH_W'(float_default_q);
				end
				fle_pkg::CH_S: begin
					do_add  = 1'b1;
					add_len = (width_q > slen_s1) ? width_q : slen_s1;
				end
				fle_pkg::CH_C: begin
					do_add = 1'b1;
				end
				fle_pkg::CH_P: begin
					do_add  = 1'b1;
					add_len = fle_pkg::WIDTH_W'(pointer_q);
				end
				default: begin
					// %n and unknown letters close the specifier with no length.
				end
			endcase
		end else if (mode_q == MODE_SPEC) begin
			if (is_numeral) begin
				width_d = (width_mul[fle_pkg::WIDTH_W+3:fle_pkg::WIDTH_W] != '0) ?
					fle_pkg::WIDTH_MAX : width_mul[fle_pkg::WIDTH_W-1:0];
			end else if (char_s1 == fle_pkg::CH_DOT) begin
				mode_d = MODE_DOT;
			end else if (char_s1 == fle_pkg::CH_PERCENT) begin
				do_add = 1'b1;
				mode_d = MODE_TEXT;
			end
		end else if (mode_q == MODE_DOT) begin
			// Everything but a letter is skipped after the precision dot.
		end else begin
			if (char_s1 == fle_pkg::CH_PERCENT) begin
				mode_d  = MODE_SPEC;
				width_d = '0;
			end else begin
				do_add = 1'b1;
			end
		end
	end

	// Saturating running total.
	assign total_sum = {1'b0, total_q} + (LENGTH_BITS+1)'(add_len);
	assign total_add = total_sum[LENGTH_BITS] ? '1 : total_sum[LENGTH_BITS-1:0];

	// Clamp the total to the 32-bit output range for any total width.
	assign total_ext = {{fle_pkg::OUT_W{1'b0}}, total_q};
	assign total_out = (total_ext[LENGTH_BITS+fle_pkg::OUT_W-1:fle_pkg::OUT_W] != '0) ?
		'1 : total_ext[fle_pkg::OUT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_default_q   <= fle_pkg::INT_DEFAULT_RST;
			float_default_q <= fle_pkg::FLOAT_DEFAULT_RST;
			pointer_q       <= fle_pkg::POINTER_RST;
			valid_s1        <= 1'b0;
			char_s1         <= '0;
			slen_s1         <= '0;
			mode_q          <= MODE_TEXT;
			width_q         <= '0;
			total_q         <= '0;
			out_valid_q     <= 1'b0;
			out_len_q       <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_addr)
					fle_pkg::CFG_INT_DEFAULT:   int_default_q   <= cfg_wdata;
					fle_pkg::CFG_FLOAT_DEFAULT: float_default_q <= cfg_wdata;
					fle_pkg::CFG_POINTER:       pointer_q       <= cfg_wdata;
					default: begin
						// Writes beyond the register list are dropped.
					end
				endcase
			end

			if (in_ready) begin
				valid_s1 <= in_valid;
				if (in_valid) begin
					char_s1 <= format_char;
					slen_s1 <= string_arg_length;
				end
			end

			if (out_valid_q && out_ready && !(s1_fire && is_nul)) begin
				out_valid_q <= 1'b0;
			end

			if (s1_fire) begin
				if (is_nul) begin
					out_valid_q <= 1'b1;
					out_len_q   <= total_out;
					mode_q      <= MODE_TEXT;
					width_q     <= '0;
					total_q     <= '0;
				end else begin
					mode_q  <= mode_d;
					width_q <= width_d;
					if (do_add) begin
						total_q <= total_add;
					end
				end
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign estimated_length = out_len_q;

	// A NUL byte leaves the scanner fully cleared.
	a_nul_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && is_nul |=> total_q == '0 && width_q == '0 && mode_q == MODE_TEXT)
		else $error("scan state not cleared after string end");

	// A byte only lingers in the input register when it is a NUL facing a stall.
	a_hold_reason: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_fire |-> is_nul && out_valid_q && !out_ready)
		else $error("input register stalled without a blocked total");

	// The running total never shrinks between string ends.
	a_total_grows: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && !is_nul |=> total_q >= $past(total_q))
		else $error("running total decreased");

	// A total is produced exactly when a NUL byte is processed.
	a_out_from_nul: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q ##1 out_valid_q |-> $past(s1_fire && is_nul))
		else $error("total presented without a string end");

endmodule

>>> tb/fle_length_checker.sv
module fle_length_checker
	import fle_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [CHAR_W-1:0]    format_char,
	input  logic [SLEN_W-1:0]    string_arg_length,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [OUT_W-1:0]     estimated_length,
	output int                   fail_count,
	output int                   totals_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {
		SCAN_TEXT,
		SCAN_SPEC,
		SCAN_DOT
	} scan_mode_t;

	scan_mode_t         mode;
	logic [WIDTH_W-1:0] spec_width;
	logic [OUT_W-1:0]   running_len;
	logic [CFG_W-1:0]   int_dflt;
	logic [CFG_W-1:0]   flt_dflt;
	logic [CFG_W-1:0]   ptr_len;
	logic [OUT_W-1:0]   totals_q[$];
	logic [OUT_W-1:0]   expected_len;

	// The running total sticks at all ones once it would overflow.
	function automatic logic [OUT_W-1:0] sat_add(input logic [OUT_W-1:0] a,
			input logic [OUT_W-1:0] n);
		logic [OUT_W:0] s;
		s = {1'b0, a} + {1'b0, n};
		return s[OUT_W] ? '1 : s[OUT_W-1:0];
	endfunction

	function automatic logic letter_code(input logic [CHAR_W-1:0] c);
		return (c >= CH_UC_A && c <= CH_UC_Z) || (c >= CH_LC_A && c <= CH_LC_Z);
	endfunction

	task automatic close_conversion(input logic [CHAR_W-1:0] c,
			input logic [SLEN_W-1:0] slen);
		logic keep_spec;
		keep_spec = 1'b0;
		case (c)
			CH_L_LC, CH_H, CH_L_UC, CH_W: keep_spec = 1'b1;
			CH_D, CH_I, CH_O, CH_X_LC, CH_X_UC, CH_U:
				running_len = sat_add(running_len,
					(spec_width != '0) ? 32'(spec_width) : 32'(int_dflt));
			CH_F, CH_G_LC, CH_E_LC, CH_G_UC, CH_E_UC:
				running_len = sat_add(running_len,
					(spec_width != '0) ? 32'(spec_width) : 32'(flt_dflt));
			CH_S:
				running_len = sat_add(running_len,
					(spec_width > slen) ? 32'(spec_width) : 32'(slen));
			CH_C: running_len = sat_add(running_len, 32'd1);
			CH_P: running_len = sat_add(running_len, 32'(ptr_len));
			default: ;
		endcase
		mode = keep_spec ? SCAN_SPEC : SCAN_TEXT;
	endtask

	task automatic absorb_char(input logic [CHAR_W-1:0] c, input logic [SLEN_W-1:0] slen);
		logic [19:0] w;
		if (c == CH_NUL) begin
			totals_q.push_back(running_len);
			mode        = SCAN_TEXT;
			spec_width  = '0;
			running_len = '0;
		end else begin
			case (mode)
				SCAN_SPEC: begin
					if (letter_code(c)) begin
						close_conversion(c, slen);
					end else if (c >= CH_0 && c <= CH_9) begin
						w = 20'(spec_width) * 20'd10 + 20'(c - CH_0);
						spec_width = (w > 20'(WIDTH_MAX)) ? WIDTH_MAX : w[WIDTH_W-1:0];
					end else if (c == CH_DOT) begin
						mode = SCAN_DOT;
					end else if (c == CH_PERCENT) begin
						running_len = sat_add(running_len, 32'd1);
						mode = SCAN_TEXT;
					end
				end
				SCAN_DOT: begin
					if (letter_code(c))
						close_conversion(c, slen);
				end
				default: begin
					if (c == CH_PERCENT) begin
						mode       = SCAN_SPEC;
						spec_width = '0;
					end else begin
						running_len = sat_add(running_len, 32'd1);
					end
				end
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode        = SCAN_TEXT;
			spec_width  = '0;
			running_len = '0;
			int_dflt    = INT_DEFAULT_RST;
			flt_dflt    = FLOAT_DEFAULT_RST;
			ptr_len     = POINTER_RST;
			totals_q.delete();
			fail_count  = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_addr)
					CFG_INT_DEFAULT:   int_dflt = cfg_wdata;
					CFG_FLOAT_DEFAULT: flt_dflt = cfg_wdata;
					CFG_POINTER:       ptr_len  = cfg_wdata;
					default: ;
				endcase
			end
			// Results are checked before this edge's input is absorbed, so a
			// stray output can never be matched by a total queued right now.
			if (out_valid && out_ready) begin
				if (totals_q.size() == 0) begin
					$display("%t: unexpected total transfer: expected none, actual %0d",
						$time, estimated_length);
					fail_count++;
				end else begin
					expected_len = totals_q.pop_front();
					if (estimated_length !== expected_len) begin
						$display("%t: estimated_length mismatch: expected %0d, actual %0d",
							$time, expected_len, estimated_length);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				absorb_char(format_char, string_arg_length);
		end
		totals_pending = totals_q.size();
	end

endmodule

>>> tb/tb.sv
module tb;
	import fle_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Run limit for the watchdog; it leaves a wide margin above the length of
	// a correct run, even with every stall.
	localparam int CYCLE_LIMIT  = 50_000;
	// Input register plus processing stage, with some slack.
	localparam int DRAIN_CYCLES = 8;
	// Length of the long receiver hold-off used to fill the block.
	localparam int HOLD_CYCLES  = 120;
	localparam int PHASE_ITEMS  = 55;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_addr;
	logic [CFG_W-1:0]     cfg_wdata;
	logic                 in_valid;
	logic                 in_ready;
	logic [CHAR_W-1:0]    format_char;
	logic [SLEN_W-1:0]    string_arg_length;
	logic                 out_valid;
	logic                 out_ready;
	logic [OUT_W-1:0]     estimated_length;

	int   checker_fails;
	int   totals_pending;
	int   cycles = 0;
	int   items_sent = 0;
	// When set, neither side inserts random idle cycles.
	logic no_idle = 1'b0;
	// The stimulus bumps this count to ask the receiver for a long hold-off.
	int   hold_reqs = 0;

	format_length_estimator dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_addr         (cfg_addr),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.format_char      (format_char),
		.string_arg_length(string_arg_length),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.estimated_length (estimated_length)
	);

	fle_length_checker length_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_addr         (cfg_addr),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.format_char      (format_char),
		.string_arg_length(string_arg_length),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.estimated_length (estimated_length),
		.fail_count       (checker_fails),
		.totals_pending   (totals_pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog: a hung handshake or a total that never arrives ends here.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver. Outputs change only at the falling edge, so the block sees a
	// stable out_ready at every rising edge. A hold-off request holds out_ready low,
	// overriding the random stalls, until the counter loaded from HOLD_CYCLES runs out.
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_reqs != hold_seen) begin
				hold_seen = hold_reqs;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= no_idle || ($urandom_range(99) >= 13);
			end
		end
	end

	// Offer one character and return once its transfer has happened. The
	// handshake is sampled at the rising edge, before the block updates
	// in_ready, so the value seen is the one that decided the transfer.
	task automatic send_char(input logic [CHAR_W-1:0] c, input logic [SLEN_W-1:0] slen);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < 13) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid          <= 1'b1;
		format_char       <= c;
		string_arg_length <= slen;
		do
			@(posedge clk);
		while (!in_ready);
		items_sent++;
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Stop offering, wait for every queued total, then let the pipeline empty
	// so a following register write cannot overlap a character in flight.
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (totals_pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mostly short argument lengths, with both extremes and full-range values.
	function automatic logic [SLEN_W-1:0] rand_slen();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return '0;
		else if (r < 20)
			return '1;
		else if (r < 40)
			return SLEN_W'($urandom_range(65535));
		else
			return SLEN_W'($urandom_range(40));
	endfunction

	// Letters with a meaning inside a specifier; the last four are modifiers.
	function automatic logic [CHAR_W-1:0] conv_letter(input int idx);
		case (idx)
			0:  return CH_D;
			1:  return CH_I;
			2:  return CH_O;
			3:  return CH_X_LC;
			4:  return CH_X_UC;
			5:  return CH_U;
			6:  return CH_F;
			7:  return CH_G_LC;
			8:  return CH_E_LC;
			9:  return CH_G_UC;
			10: return CH_E_UC;
			11: return CH_S;
			12: return CH_C;
			13: return CH_P;
			14: return CH_N;
			15: return CH_L_LC;
			16: return CH_H;
			17: return CH_L_UC;
			default: return CH_W;
		endcase
	endfunction

	function automatic logic [CHAR_W-1:0] digit_char();
		return CH_0 + CHAR_W'($urandom_range(9));
	endfunction

	// One conversion specifier: optional noise, width digits, precision,
	// modifier, and a closing letter that is usually a known conversion.
	task automatic send_spec();
		int ndig;
		int r;
		send_char(CH_PERCENT, rand_slen());
		if ($urandom_range(9) == 0)
			send_char(CHAR_W'($urandom_range(1, 255)), rand_slen());
		ndig = ($urandom_range(9) < 7) ? $urandom_range(2) : $urandom_range(3, 6);
		repeat (ndig) send_char(digit_char(), rand_slen());
		if ($urandom_range(3) == 0) begin
			send_char(CH_DOT, rand_slen());
			repeat ($urandom_range(2)) send_char(digit_char(), rand_slen());
			if ($urandom_range(4) == 0)
				send_char(CHAR_W'($urandom_range(1, 255)), rand_slen());
		end
		if ($urandom_range(4) == 0)
			send_char(conv_letter($urandom_range(15, 18)), rand_slen());
		r = $urandom_range(99);
		if (r < 85)
			send_char(conv_letter($urandom_range(18)), rand_slen());
		else if (r < 95)
			send_char(($urandom_range(1) ? CH_UC_A : CH_LC_A) + CHAR_W'($urandom_range(25)),
				rand_slen());
		else
			send_char(CH_PERCENT, rand_slen());
	endtask

	// A whole format string: text and specifiers ended by NUL. A few strings
	// are cut off by a NUL in the middle of a specifier.
	task automatic send_random_string();
		int segs;
		int r;
		segs = $urandom_range(1, 6);
		for (int k = 0; k < segs; k++) begin
			r = $urandom_range(99);
			if (r < 30) begin
				send_char(CHAR_W'($urandom_range(1, 255)), rand_slen());
			end else if (r < 35) begin
				send_char(CH_PERCENT, rand_slen());
				if ($urandom_range(1))
					send_char(digit_char(), rand_slen());
				if ($urandom_range(1))
					send_char(CH_DOT, rand_slen());
				break;
			end else begin
				send_spec();
			end
		end
		send_char(CH_NUL, rand_slen());
	endtask

	initial begin
		logic [CFG_W-1:0] iw;
		logic [CFG_W-1:0] fw;
		logic [CFG_W-1:0] pw;
		int               phase_start;

		arst_n            = 1'b0;
		cfg_wr_en         = 1'b0;
		cfg_addr          = CFG_INT_DEFAULT;
		cfg_wdata         = '0;
		in_valid          = 1'b0;
		format_char       = CH_NUL;
		string_arg_length = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// Directed strings under the reset defaults. Plain text including a
		// letter and a byte above 0x7F, then a literal percent.
		send_char(CH_UC_A, '1);
		send_char(8'hFF, '0);
		send_char(CH_PERCENT, '0);
		send_char(CH_PERCENT, '0);
		// A width far past 65535 saturates before the integer conversion.
		send_char(CH_PERCENT, '0);
		repeat (6) send_char(CH_9, '0);
		send_char(CH_D, '0);
		// Digits after the dot are ignored; width 3 beats a length of 2.
		send_char(CH_PERCENT, '0);
		send_char(CH_0 + 8'd3, '0);
		send_char(CH_DOT, '0);
		send_char(CH_0 + 8'd7, '0);
		send_char(CH_S, 16'd2);
		// A modifier keeps the specifier open, a stray sign is ignored, and
		// the conversion falls back to the integer default.
		send_char(CH_PERCENT, '0);
		send_char(CH_L_LC, '0);
		send_char("-", '0);
		send_char(CH_U, '0);
		send_char(CH_PERCENT, '0);
		send_char(CH_P, '0);
		// NUL in the middle of a specifier reports the total as it stands.
		send_char(CH_PERCENT, '0);
		send_char(CH_0 + 8'd5, '0);
		send_char(CH_NUL, '0);
		wait_idle();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					iw = '0;
					fw = '0;
					pw = '0;
				end
				1: begin
					iw = '1;
					fw = '1;
					pw = '1;
				end
				4: begin
					iw = 8'd1;
					fw = 8'd128;
					pw = 8'd254;
				end
				default: begin
					iw = CFG_W'($urandom_range(255));
					fw = CFG_W'($urandom_range(255));
					pw = CFG_W'($urandom_range(255));
				end
			endcase
			cfg_write(CFG_INT_DEFAULT, iw);
			cfg_write(CFG_FLOAT_DEFAULT, fw);
			cfg_write(CFG_POINTER, pw);

			if (phase == 3) begin
				// The receiver stalls for a long stretch while short strings
				// keep coming, so totals back up and in_ready must drop.
				hold_reqs++;
				repeat (10) begin
					send_char(CH_PERCENT, rand_slen());
					send_char(conv_letter($urandom_range(14)), rand_slen());
					send_char(CH_NUL, rand_slen());
				end
			end
			// The last phase runs without any random idling on either side.
			no_idle = (phase == 5);

			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS)
				send_random_string();
			wait_idle();
			no_idle = 1'b0;
		end

		if (checker_fails == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
